// ===== hdl/metaball_field_posterize_unit_defines.svh =====
// Assertion macros used by the checker.
`ifndef METABALL_FIELD_POSTERIZE_UNIT_DEFINES_SVH
`define METABALL_FIELD_POSTERIZE_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define MFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, masked during reset.
`define MFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also holds across reset.
`define MFP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/mfp_pkg.sv =====
`default_nettype none
package mfp_pkg;

  localparam int SLOTS      = 6;
  localparam int SETUP_W    = 49;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BANDS = 3'd6;
  localparam logic [7:0] BANDS_RESET = 8'd8;

  localparam int DIFF_W     = 17;
  localparam int SQ_W       = 34;
  localparam int D2_W       = 36;   // padded to an even count
  localparam int ROOT_W     = 18;
  localparam int SQRT_STEPS = 18;
  localparam int SREM_W     = 20;
  localparam int NUM_W      = 28;
  localparam int DIV_STEPS  = 28;
  // 3 distance stages, sqrt steps, divider load, divide steps
  localparam int LANE_LAT   = 4 + SQRT_STEPS + DIV_STEPS;

  localparam int SUM_W      = 31;
  localparam int GDIV_STEPS = 8;
  localparam int POST_LAT   = 5 + GDIV_STEPS + 1;

  typedef struct packed {
    logic        en;
    logic [15:0] rad;
    logic [15:0] cy;
    logic [15:0] cx;
  } ball_cfg_t;

  typedef struct packed {
    logic             sat;
    logic [NUM_W-1:0] q;
  } term_t;

endpackage
`default_nettype wire

// ===== hdl/mfp_lane.sv =====
`default_nettype none
// One ball: distance, integer sqrt, then radius/distance in Q.16.
module mfp_lane (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [11:0]       pix_x,
  input  wire logic [11:0]       pix_y,
  input  wire mfp_pkg::ball_cfg_t cfg,
  output mfp_pkg::term_t         term
);

  localparam int SS = mfp_pkg::SQRT_STEPS;
  localparam int DS = mfp_pkg::DIV_STEPS;

  logic signed [17:0] dx_s, dy_s;
  logic [mfp_pkg::DIFF_W-1:0] ax_nxt, ay_nxt, ax_r, ay_r;
  logic [mfp_pkg::SQ_W-1:0] sqx_r, sqy_r;
  logic en_a_r, en_b_r;
  logic [15:0] rad_a_r, rad_b_r;

  logic [mfp_pkg::D2_W-1:0]   sq_d2_r   [0:SS];
  logic [mfp_pkg::SREM_W-1:0] sq_rem_r  [0:SS];
  logic [mfp_pkg::ROOT_W-1:0] sq_root_r [0:SS];
  logic                       sq_en_r   [0:SS];
  logic [15:0]                sq_rad_r  [0:SS];

  logic [mfp_pkg::NUM_W-1:0]  dv_num_r  [0:DS];
  logic [mfp_pkg::ROOT_W-1:0] dv_rem_r  [0:DS];
  logic [mfp_pkg::NUM_W-1:0]  dv_q_r    [0:DS];
  logic [mfp_pkg::ROOT_W-1:0] dv_dist_r [0:DS];
  logic                       dv_en_r   [0:DS];

  always_comb begin
    dx_s = $signed({2'b00, pix_x, 4'b0000}) - $signed({{2{cfg.cx[15]}}, cfg.cx});
    dy_s = $signed({2'b00, pix_y, 4'b0000}) - $signed({{2{cfg.cy[15]}}, cfg.cy});
    ax_nxt = dx_s[17] ? 17'(-dx_s) : dx_s[16:0];
    ay_nxt = dy_s[17] ? 17'(-dy_s) : dy_s[16:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      en_a_r   <= cfg.en;
      rad_a_r  <= cfg.rad;
      sqx_r    <= ax_r * ax_r;
      sqy_r    <= ay_r * ay_r;
      en_b_r   <= en_a_r;
      rad_b_r  <= rad_a_r;
      sq_d2_r[0]   <= {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_en_r[0]   <= en_b_r;
      sq_rad_r[0]  <= rad_b_r;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam int BI = SS - 1 - k;
    logic [mfp_pkg::SREM_W+1:0] sh;
    logic [mfp_pkg::SREM_W+1:0] trial;
    always_comb begin
      sh    = {sq_rem_r[k], sq_d2_r[k][2*BI+1 -: 2]};
      trial = {2'b00, sq_root_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_d2_r[k+1]  <= sq_d2_r[k];
        sq_en_r[k+1]  <= sq_en_r[k];
        sq_rad_r[k+1] <= sq_rad_r[k];
        if (sh >= trial) begin
          sq_rem_r[k+1]  <= mfp_pkg::SREM_W'(sh - trial);
          sq_root_r[k+1] <= {sq_root_r[k][mfp_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_r[k+1]  <= mfp_pkg::SREM_W'(sh);
          sq_root_r[k+1] <= {sq_root_r[k][mfp_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_num_r[0]  <= {sq_rad_r[SS], 12'h000};
      dv_rem_r[0]  <= '0;
      dv_q_r[0]    <= '0;
      dv_dist_r[0] <= sq_root_r[SS];
      dv_en_r[0]   <= sq_en_r[SS];
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int BI = DS - 1 - j;
    logic [mfp_pkg::ROOT_W:0] r;
    always_comb r = {dv_rem_r[j], dv_num_r[j][BI]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_num_r[j+1]  <= dv_num_r[j];
        dv_dist_r[j+1] <= dv_dist_r[j];
        dv_en_r[j+1]   <= dv_en_r[j];
        if (r >= {1'b0, dv_dist_r[j]}) begin
          dv_rem_r[j+1] <= mfp_pkg::ROOT_W'(r - {1'b0, dv_dist_r[j]});
          dv_q_r[j+1]   <= {dv_q_r[j][mfp_pkg::NUM_W-2:0], 1'b1};
        end else begin
          dv_rem_r[j+1] <= mfp_pkg::ROOT_W'(r);
          dv_q_r[j+1]   <= {dv_q_r[j][mfp_pkg::NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    term.sat = dv_en_r[DS] && (dv_dist_r[DS] == '0);
    term.q   = (dv_en_r[DS] && (dv_dist_r[DS] != '0)) ? dv_q_r[DS] : '0;
  end

endmodule
`default_nettype wire

// ===== hdl/mfp_post.sv =====
`default_nettype none
// Sum of ball terms, saturation, banding and grey division.
module mfp_post (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           in_vld,
  input  wire mfp_pkg::term_t terms [mfp_pkg::SLOTS],
  input  wire logic [7:0]     bands,
  output logic                out_vld,
  output logic [7:0]          grey,
  output logic                sat
);

  localparam int GS = mfp_pkg::GDIV_STEPS;

  logic [mfp_pkg::SUM_W-1:0] s01_r, s23_r, s45_r, sum_r;
  logic        sat1_r, sat2_r, sat3_r, sat4_r;
  logic [23:0] prod;
  logic [7:0]  level_r;
  logic [15:0] num_r;
  logic [3:0]  vld_r;

  logic [7:0]  gd_rem_r [0:GS];
  logic [7:0]  gd_low_r [0:GS];
  logic [7:0]  gd_q_r   [0:GS];
  logic        gd_sat_r [0:GS];
  logic        gd_vld_r [0:GS];

  logic        out_vld_r, out_sat_r;
  logic [7:0]  out_grey_r;

  always_comb prod = sum_r[15:0] * bands;

  always_ff @(posedge clk) begin
    if (adv) begin
      s01_r   <= mfp_pkg::SUM_W'(terms[0].q) + mfp_pkg::SUM_W'(terms[1].q);
      s23_r   <= mfp_pkg::SUM_W'(terms[2].q) + mfp_pkg::SUM_W'(terms[3].q);
      s45_r   <= mfp_pkg::SUM_W'(terms[4].q) + mfp_pkg::SUM_W'(terms[5].q);
      sat1_r  <= terms[0].sat | terms[1].sat | terms[2].sat |
                 terms[3].sat | terms[4].sat | terms[5].sat;
      sum_r   <= s01_r + s23_r + s45_r;
      sat2_r  <= sat1_r;
      level_r <= prod[23:16];
      sat3_r  <= sat2_r | (sum_r[mfp_pkg::SUM_W-1:16] != '0);
      num_r   <= {level_r, 8'h00} - {8'h00, level_r};
      sat4_r  <= sat3_r;
      gd_rem_r[0] <= num_r[15:8];
      gd_low_r[0] <= num_r[7:0];
      gd_q_r[0]   <= '0;
      gd_sat_r[0] <= sat4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      gd_vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[2:0], in_vld};
      gd_vld_r[0] <= vld_r[3];
    end
  end

  // level*255/bands, quotient fits 8 bits since level < bands
  for (genvar j = 0; j < GS; j++) begin : g_gdiv
    localparam int BI = GS - 1 - j;
    logic [8:0] r;
    always_comb r = {gd_rem_r[j], gd_low_r[j][BI]};
    always_ff @(posedge clk) begin
      if (adv) begin
        gd_low_r[j+1] <= gd_low_r[j];
        gd_sat_r[j+1] <= gd_sat_r[j];
        if (r >= {1'b0, bands}) begin
          gd_rem_r[j+1] <= 8'(r - {1'b0, bands});
          gd_q_r[j+1]   <= {gd_q_r[j][6:0], 1'b1};
        end else begin
          gd_rem_r[j+1] <= r[7:0];
          gd_q_r[j+1]   <= {gd_q_r[j][6:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        gd_vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        gd_vld_r[j+1] <= gd_vld_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sat_r  <= gd_sat_r[GS];
      out_grey_r <= gd_sat_r[GS] ? 8'hFF : gd_q_r[GS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= gd_vld_r[GS];
    end
  end

  assign out_vld = out_vld_r;
  assign grey    = out_grey_r;
  assign sat     = out_sat_r;

endmodule
`default_nettype wire

// ===== hdl/metaball_field_posterize_unit.sv =====
// Channel  | Handshake          | Beat contents
// ---------+--------------------+------------------------------------------
// input    | in_valid/in_stall  | in_pixel_x, in_pixel_y
// result   | out_valid/out_stall| out_grey_level, out_saturated
// config   | cfg_we             | cfg_index, cfg_data
//
// One beat in and one beat out per clock, sustained while out_stall is low.
// A beat passes 64 register stages from the accepting edge to out_valid:
// per ball 3 distance, 18 sqrt, 1 divider load, 28 divide; then 14 stages of
// summing, banding, grey division and the output register.
// rst_n is synchronous: clears valid bits and config (balls off, 8 bands).
// The whole pipeline holds while the output register is full and stalled.
`default_nettype none
module metaball_field_posterize_unit #(
  parameter int BALL_COUNT = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_grey_level,
  output logic             out_saturated,
  input  wire logic        cfg_we,
  input  wire logic [mfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mfp_pkg::SETUP_W-1:0]   cfg_data
);

  localparam int LL = mfp_pkg::LANE_LAT;

  logic [mfp_pkg::SETUP_W-1:0] ball_r [mfp_pkg::SLOTS];
  logic [7:0] bands_r;
  logic [7:0] bands_eff;
  logic       adv;
  logic [LL-1:0] vpipe_r;
  mfp_pkg::term_t terms [mfp_pkg::SLOTS];
  logic       post_vld;

  // config registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfp_pkg::SLOTS; i++) ball_r[i] <= '0;
      bands_r <= mfp_pkg::BANDS_RESET;
    end else if (cfg_we) begin
      if (cfg_index < mfp_pkg::CFG_IDX_W'(mfp_pkg::SLOTS)) begin
        ball_r[cfg_index] <= cfg_data;
      end else if (cfg_index == mfp_pkg::CFG_IDX_BANDS) begin
        bands_r <= cfg_data[7:0];
      end
    end
  end

  // zero bands behaves as one band
  assign bands_eff = (bands_r == 8'h00) ? 8'h01 : bands_r;

  // global advance: move unless the output holds an unaccepted beat
  assign adv      = !post_vld || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else if (adv) begin
      vpipe_r <= {vpipe_r[LL-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < mfp_pkg::SLOTS; i++) begin : g_ball
    if (i < BALL_COUNT) begin : g_on
      mfp_lane u_lane (
        .clk   (clk),
        .adv   (adv),
        .pix_x (in_pixel_x),
        .pix_y (in_pixel_y),
        .cfg   (mfp_pkg::ball_cfg_t'(ball_r[i])),
        .term  (terms[i])
      );
    end else begin : g_off
      assign terms[i] = '0;
    end
  end

  mfp_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (vpipe_r[LL-1]),
    .terms   (terms),
    .bands   (bands_eff),
    .out_vld (post_vld),
    .grey    (out_grey_level),
    .sat     (out_saturated)
  );

  assign out_valid = post_vld;

endmodule
`default_nettype wire

// ===== hdl/mfp_checker.sv =====
`default_nettype none
`include "metaball_field_posterize_unit_defines.svh"
module mfp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_grey_level,
  input wire logic       out_saturated
);

  `MFP_ASSERT_NOW(a_sat_white, clk, rst_n, out_valid && out_saturated, out_grey_level == 8'hFF)
  `MFP_ASSERT_NOW(a_stall_path, clk, rst_n, 1'b1, in_stall == (out_valid && out_stall))
  `MFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_grey_level) && $stable(out_saturated))
  `MFP_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)

endmodule

bind metaball_field_posterize_unit mfp_checker u_mfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_grey_level (out_grey_level),
  .out_saturated  (out_saturated)
);
`default_nettype wire
